// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

  // receive and status buffer depth in bytes
  localparam int BUFFER_DEPTH = 64;
  localparam int IDX_W = $clog2(BUFFER_DEPTH);
  localparam int POS_W = $clog2(BUFFER_DEPTH + 1);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // bus phases
  localparam logic [1:0] PH_ADDR  = 2'd0;
  localparam logic [1:0] PH_WRITE = 2'd1;
  localparam logic [1:0] PH_READ  = 2'd2;
  localparam logic [1:0] PH_LAST  = 2'd3;

  // player modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_SIMON = 3'd1;
  localparam logic [2:0] MODE_ETCH  = 3'd2;
  localparam logic [2:0] MODE_RUBIK = 3'd3;
  localparam logic [2:0] MODE_CARDS = 3'd4;

  // request classes from the front
  localparam logic [1:0] OP_BUS_DATA = 2'd0;
  localparam logic [1:0] OP_BUS_ZERO = 2'd1;
  localparam logic [1:0] OP_DONE     = 2'd2;

  // command words, first character in the top byte
  localparam logic [39:0] WORD_SIMON = 40'h53_69_6D_6F_6E;
  localparam logic [39:0] WORD_ETCH  = 40'h45_74_63_68_2E;
  localparam logic [39:0] WORD_RUBIK = 40'h52_75_62_69_6B;
  localparam logic [39:0] WORD_CARDS = 40'h43_61_72_64_73;
  localparam logic [23:0] WORD_DIS   = 24'h44_69_73;

  typedef struct packed {
    logic       command;
    logic       read_not_write;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] game_request;
    logic [2:0] player_mode_out;
    logic       display_valid;
    logic [7:0] display_value;
    logic       overflow;
  } out_t;

  typedef struct packed {
    logic [1:0] op;
    logic       rnw;
    logic [7:0] rx;
  } item_t;

  // idle status string image, zero past the text
  function automatic logic [7:0] idle_char(input logic [IDX_W-1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (idx == IDX_W'(0)) c = 8'h49;
    if (idx == IDX_W'(1)) c = 8'h64;
    if (idx == IDX_W'(2)) c = 8'h6C;
    if (idx == IDX_W'(3)) c = 8'h65;
    if (idx == IDX_W'(4)) c = 8'h2E;
    return c;
  endfunction

endpackage

// ===== rtl/core/i2c_slave_command_mailbox_core.sv =====
// I2C slave command mailbox: takes one bus or game-done request per transfer and
// returns exactly one result for each. Requests pass a holding stage and a
// four-entry queue, so the input keeps accepting while results wait until both
// are full; the execute unit takes one request at a time (buffer read address,
// then registered read data and state update once the result slot is free).
// Command and status bytes live in one memory of two banks that swap roles when
// a command completes, so no copy pass is needed. No clearing pass after reset.
module i2c_slave_command_mailbox_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  i2cm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output i2cm_pkg::out_t out_data
);

  logic            q_full;
  logic            q_push;
  i2cm_pkg::item_t q_in;
  logic            q_valid;
  logic            q_pop;
  i2cm_pkg::item_t q_head;

  // classify and hold incoming requests
  i2cm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // decoupling queue
  i2cm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .din        (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // execute and produce results
  i2cm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/i2cm_front.sv =====
module i2cm_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  i2cm_pkg::in_t   in_data,
  input  logic            q_full,
  output logic            q_push,
  output i2cm_pkg::item_t q_item
);

  logic            hold_valid;
  i2cm_pkg::item_t hold;
  i2cm_pkg::item_t classified;
  logic            accept;

  // classify the incoming request
  always_comb begin
    classified.rnw = in_data.read_not_write;
    classified.rx  = in_data.rx_byte;
    if (in_data.command) begin
      classified.op = i2cm_pkg::OP_DONE;
    end else if (in_data.rx_byte == 8'h00) begin
      classified.op = i2cm_pkg::OP_BUS_ZERO;
    end else begin
      classified.op = i2cm_pkg::OP_BUS_DATA;
    end
  end

  // one holding stage in front of the queue
  assign q_push   = hold_valid && !q_full;
  assign in_stall = hold_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_item   = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= classified;
    end
  end

endmodule

// ===== rtl/core/i2cm_queue.sv =====
module i2cm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2cm_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output i2cm_pkg::item_t head
);

  i2cm_pkg::item_t                     slots [i2cm_pkg::QUEUE_DEPTH];
  logic [i2cm_pkg::QPTR_W-1:0]         wr_ptr;
  logic [i2cm_pkg::QPTR_W-1:0]         rd_ptr;
  logic [i2cm_pkg::QCNT_W-1:0]         count;

  assign full       = (count == i2cm_pkg::QCNT_W'(i2cm_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ===== rtl/core/i2cm_back.sv =====
module i2cm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  i2cm_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output i2cm_pkg::out_t  out_data
);

  localparam int AW = i2cm_pkg::IDX_W + 1;

  // two byte banks: one holds the status string, the other collects the command
  logic [7:0]                  mem [2 * i2cm_pkg::BUFFER_DEPTH];
  logic [7:0]                  rd_data;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               wr_addr;
  logic                        wr_en;

  logic                        busy;
  logic [1:0]                  phase, phase_next;
  logic [i2cm_pkg::POS_W-1:0]  pos, pos_next;
  logic                        sb, sb_next;
  logic                        status_idle, status_idle_next;
  logic [i2cm_pkg::POS_W-1:0]  slen, slen_next;
  logic [2:0]                  mode, mode_next;
  logic [39:0]                 cmd_head;

  logic                        start;
  logic                        finish;
  logic [i2cm_pkg::IDX_W-1:0]  rd_idx;
  logic                        pos_in;
  logic                        in_status;
  logic [7:0]                  status_byte;
  logic [7:0]                  b3, b4;
  i2cm_pkg::out_t              res;

  assign start  = q_valid && !busy;
  assign finish = busy && (!out_valid || !out_stall);
  assign q_pop  = finish;

  assign rd_idx  = (phase == i2cm_pkg::PH_ADDR) ? '0 : pos[i2cm_pkg::IDX_W-1:0];
  assign rd_addr = {sb, rd_idx};
  assign wr_addr = {~sb, pos[i2cm_pkg::IDX_W-1:0]};
  assign pos_in  = (pos < i2cm_pkg::POS_W'(i2cm_pkg::BUFFER_DEPTH));

  // memory with registered read
  always_ff @(posedge clk) begin
    if (start) begin
      rd_data <= mem[rd_addr];
    end
    if (finish && wr_en) begin
      mem[wr_addr] <= q_item.rx;
    end
  end

  // status byte at the read index, zero past the stored length
  assign in_status = (phase == i2cm_pkg::PH_ADDR) ? (slen != '0) : (pos < slen);
  always_comb begin
    if (status_idle) begin
      status_byte = i2cm_pkg::idle_char(rd_idx);
    end else if (in_status) begin
      status_byte = rd_data;
    end else begin
      status_byte = 8'h00;
    end
  end

  // display digits, zero past the command length
  assign b3 = (pos > i2cm_pkg::POS_W'(3)) ? cmd_head[15:8] : 8'h00;
  assign b4 = (pos > i2cm_pkg::POS_W'(4)) ? cmd_head[7:0] : 8'h00;

  // execute one request
  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    sb_next          = sb;
    status_idle_next = status_idle;
    slen_next        = slen;
    mode_next        = mode;
    wr_en            = 1'b0;
    res              = '0;
    if (q_item.op == i2cm_pkg::OP_DONE) begin
      mode_next        = i2cm_pkg::MODE_IDLE;
      status_idle_next = 1'b1;
    end else begin
      case (phase)
        i2cm_pkg::PH_ADDR: begin
          pos_next = '0;
          if (q_item.rnw) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = status_byte;
            pos_next     = i2cm_pkg::POS_W'(1);
            phase_next   = i2cm_pkg::PH_READ;
          end else begin
            phase_next = i2cm_pkg::PH_WRITE;
          end
        end
        i2cm_pkg::PH_WRITE: begin
          if (q_item.op == i2cm_pkg::OP_BUS_ZERO) begin
            phase_next       = i2cm_pkg::PH_ADDR;
            sb_next          = ~sb;
            slen_next        = pos;
            status_idle_next = 1'b0;
            if (pos == i2cm_pkg::POS_W'(5) && cmd_head == i2cm_pkg::WORD_ETCH) begin
              mode_next        = i2cm_pkg::MODE_ETCH;
              res.game_request = i2cm_pkg::MODE_ETCH;
            end else if (pos == i2cm_pkg::POS_W'(5) && cmd_head == i2cm_pkg::WORD_RUBIK) begin
              mode_next        = i2cm_pkg::MODE_RUBIK;
              res.game_request = i2cm_pkg::MODE_RUBIK;
            end else if (pos == i2cm_pkg::POS_W'(5) && cmd_head == i2cm_pkg::WORD_SIMON) begin
              mode_next        = i2cm_pkg::MODE_SIMON;
              res.game_request = i2cm_pkg::MODE_SIMON;
            end else if (pos == i2cm_pkg::POS_W'(5) && cmd_head == i2cm_pkg::WORD_CARDS) begin
              mode_next        = i2cm_pkg::MODE_CARDS;
              res.game_request = i2cm_pkg::MODE_CARDS;
            end else if (pos >= i2cm_pkg::POS_W'(3) && cmd_head[39:16] == i2cm_pkg::WORD_DIS) begin
              res.display_valid = 1'b1;
              res.display_value = {b3[4:0], 3'b000} + {b3[6:0], 1'b0} + b4;
            end else begin
              mode_next = i2cm_pkg::MODE_IDLE;
            end
          end else if (pos_in) begin
            wr_en    = 1'b1;
            pos_next = pos + 1'b1;
          end else begin
            res.overflow = 1'b1;
          end
        end
        i2cm_pkg::PH_READ: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = pos_in ? status_byte : 8'h00;
          if (pos_in) begin
            pos_next = pos + 1'b1;
          end
          if (res.tx_byte == 8'h00) begin
            phase_next = i2cm_pkg::PH_LAST;
          end
        end
        default: begin
          phase_next = i2cm_pkg::PH_ADDR;
        end
      endcase
    end
    res.player_mode_out = mode_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      phase       <= i2cm_pkg::PH_ADDR;
      pos         <= '0;
      sb          <= 1'b1;
      status_idle <= 1'b1;
      slen        <= '0;
      mode        <= i2cm_pkg::MODE_IDLE;
      out_valid   <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        phase       <= phase_next;
        pos         <= pos_next;
        sb          <= sb_next;
        status_idle <= status_idle_next;
        slen        <= slen_next;
        mode        <= mode_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // first five command bytes kept beside the memory for matching
  always_ff @(posedge clk) begin
    if (finish && wr_en) begin
      for (int k = 0; k < 5; k++) begin
        if (pos == i2cm_pkg::POS_W'(k)) begin
          cmd_head[39 - 8 * k -: 8] <= q_item.rx;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= res;
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_REQUESTS = 1800;
  localparam logic [39:0] IDLE_TEXT = "Idle.";

  typedef struct {
    i2cm_pkg::in_t  req;
    bit             typed;
    i2cm_pkg::out_t want;
  } script_row_t;

  logic           clk;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  i2cm_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  i2cm_pkg::out_t out_data;

  // shadow copy of the mailbox state
  logic [1:0] sh_phase;
  int         sh_pos;
  logic [7:0] sh_cmd [i2cm_pkg::BUFFER_DEPTH];
  logic [7:0] sh_status [i2cm_pkg::BUFFER_DEPTH];
  logic [2:0] sh_mode;

  i2cm_pkg::out_t pending_replies[$];
  int   mismatches = 0;
  int   sent = 0;
  int   cycles = 0;
  bit   burst = 1'b0;

  i2c_slave_command_mailbox_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] word_char(input logic [39:0] w, input int i);
    return w[39 - 8 * i -: 8];
  endfunction

  function automatic i2cm_pkg::in_t bus_req(input bit c, input bit r, input logic [7:0] x);
    i2cm_pkg::in_t q;
    q.command = c;
    q.read_not_write = r;
    q.rx_byte = x;
    return q;
  endfunction

  // fields other than transmit and mode are zero
  function automatic i2cm_pkg::out_t typed_reply(input bit v, input logic [7:0] b,
                                                 input logic [2:0] m);
    i2cm_pkg::out_t o;
    o = '0;
    o.tx_valid = v;
    o.tx_byte = b;
    o.player_mode_out = m;
    return o;
  endfunction

  function automatic void load_idle_status();
    for (int i = 0; i < i2cm_pkg::BUFFER_DEPTH; i++)
      sh_status[i] = (i < 5) ? word_char(IDLE_TEXT, i) : 8'h00;
  endfunction

  // advance the shadow state by one request and return the reply it causes
  function automatic i2cm_pkg::out_t mailbox_response(input i2cm_pkg::in_t req);
    i2cm_pkg::out_t r;
    int             len;
    logic [39:0]    head;
    r = '0;
    if (req.command) begin
      sh_mode = i2cm_pkg::MODE_IDLE;
      load_idle_status();
    end else begin
      case (sh_phase)
        i2cm_pkg::PH_ADDR: begin
          sh_pos = 0;
          if (req.read_not_write) begin
            r.tx_valid = 1'b1;
            r.tx_byte = sh_status[0];
            sh_pos = 1;
            sh_phase = i2cm_pkg::PH_READ;
          end else begin
            sh_phase = i2cm_pkg::PH_WRITE;
          end
        end
        i2cm_pkg::PH_WRITE: begin
          if (req.rx_byte == 8'h00) begin
            // command complete: bytes past its length read as zero
            len = sh_pos;
            head = '0;
            for (int i = 0; i < 5; i++)
              head = {head[31:0], (i < len) ? sh_cmd[i] : 8'h00};
            if (len == 5 && head == i2cm_pkg::WORD_ETCH) begin
              sh_mode = i2cm_pkg::MODE_ETCH;
              r.game_request = i2cm_pkg::MODE_ETCH;
            end else if (len == 5 && head == i2cm_pkg::WORD_RUBIK) begin
              sh_mode = i2cm_pkg::MODE_RUBIK;
              r.game_request = i2cm_pkg::MODE_RUBIK;
            end else if (len == 5 && head == i2cm_pkg::WORD_SIMON) begin
              sh_mode = i2cm_pkg::MODE_SIMON;
              r.game_request = i2cm_pkg::MODE_SIMON;
            end else if (len == 5 && head == i2cm_pkg::WORD_CARDS) begin
              sh_mode = i2cm_pkg::MODE_CARDS;
              r.game_request = i2cm_pkg::MODE_CARDS;
            end else if (len >= 3 && head[39:16] == i2cm_pkg::WORD_DIS) begin
              r.display_valid = 1'b1;
              r.display_value = 8'(head[15:8] * 10 + head[7:0]);
            end else begin
              sh_mode = i2cm_pkg::MODE_IDLE;
            end
            for (int i = 0; i < i2cm_pkg::BUFFER_DEPTH; i++)
              sh_status[i] = (i < len) ? sh_cmd[i] : 8'h00;
            sh_phase = i2cm_pkg::PH_ADDR;
          end else if (sh_pos < i2cm_pkg::BUFFER_DEPTH) begin
            sh_cmd[sh_pos] = req.rx_byte;
            sh_pos++;
          end else begin
            r.overflow = 1'b1;
          end
        end
        i2cm_pkg::PH_READ: begin
          r.tx_valid = 1'b1;
          r.tx_byte = (sh_pos < i2cm_pkg::BUFFER_DEPTH) ? sh_status[sh_pos] : 8'h00;
          if (sh_pos < i2cm_pkg::BUFFER_DEPTH) sh_pos++;
          if (r.tx_byte == 8'h00) sh_phase = i2cm_pkg::PH_LAST;
        end
        default: begin
          sh_phase = i2cm_pkg::PH_ADDR;
        end
      endcase
    end
    r.player_mode_out = sh_mode;
    return r;
  endfunction

  // drive one request, hold it until taken, then queue its reply
  task automatic send_request(input i2cm_pkg::in_t req, input bit typed,
                              input i2cm_pkg::out_t want);
    i2cm_pkg::out_t predicted;
    int             gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = mailbox_response(req);
    pending_replies.push_back(typed ? want : predicted);
    sent++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stalls with calm stretches
  initial begin
    int             hold;
    int             calm;
    i2cm_pkg::out_t got;
    i2cm_pkg::out_t want;
    calm = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm > 0) begin
        calm--;
        hold = 0;
      end else begin
        hold = $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = out_data;
      if (pending_replies.size() == 0) begin
        $error("result with no request pending: %h", got);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("game_request", 8'(want.game_request), 8'(got.game_request));
        check_field("player_mode_out", 8'(want.player_mode_out),
                    8'(got.player_mode_out));
        check_field("display_valid", 8'(want.display_valid), 8'(got.display_valid));
        check_field("display_value", want.display_value, got.display_value);
        check_field("overflow", 8'(want.overflow), 8'(got.overflow));
      end
    end
  end

  // request side
  initial begin
    script_row_t script[];
    logic [7:0]  text[$];
    logic [39:0] w;
    int          kind;
    int          n;
    bit          drained;

    drained = 1'b0;
    sh_phase = i2cm_pkg::PH_ADDR;
    sh_pos = 0;
    sh_mode = i2cm_pkg::MODE_IDLE;
    load_idle_status();

    script = '{
      // status read right after reset, direction bit ignored mid-read
      '{bus_req(1'b0, 1'b1, 8'hFF), 1'b1, typed_reply(1'b1, "I", i2cm_pkg::MODE_IDLE)},
      '{bus_req(1'b0, 1'b1, 8'h00), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, 8'h5A), 1'b0, '0},
      '{bus_req(1'b0, 1'b1, 8'h00), 1'b0, '0},
      '{bus_req(1'b0, 1'b1, 8'h00), 1'b0, '0},
      '{bus_req(1'b0, 1'b1, 8'h00), 1'b1, typed_reply(1'b1, 8'h00, i2cm_pkg::MODE_IDLE)},
      // last-byte phase sends nothing
      '{bus_req(1'b0, 1'b1, 8'h00), 1'b1, typed_reply(1'b0, 8'h00, i2cm_pkg::MODE_IDLE)},
      // game word
      '{bus_req(1'b0, 1'b0, 8'hA5), 1'b1, typed_reply(1'b0, 8'h00, i2cm_pkg::MODE_IDLE)},
      '{bus_req(1'b0, 1'b0, "E"), 1'b0, '0},
      '{bus_req(1'b0, 1'b1, "t"), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, "c"), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, "h"), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, "."), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, 8'h00), 1'b0, '0},
      // display with largest digits
      '{bus_req(1'b0, 1'b0, 8'h00), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, "D"), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, "i"), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, "s"), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, 8'hFF), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, 8'hFF), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, 8'h00), 1'b0, '0},
      // game done
      '{bus_req(1'b1, 1'b1, 8'hFF), 1'b1, typed_reply(1'b0, 8'h00, i2cm_pkg::MODE_IDLE)},
      // empty command, then read of the empty status
      '{bus_req(1'b0, 1'b0, 8'h00), 1'b0, '0},
      '{bus_req(1'b0, 1'b0, 8'h00), 1'b0, '0},
      '{bus_req(1'b0, 1'b1, 8'h00), 1'b1, typed_reply(1'b1, 8'h00, i2cm_pkg::MODE_IDLE)},
      '{bus_req(1'b0, 1'b1, 8'h00), 1'b0, '0},
      '{bus_req(1'b0, 1'b1, 8'h00), 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_request(script[i].req, script[i].typed, script[i].want);

    while (sent < RANDOM_REQUESTS) begin
      burst = ($urandom_range(0, 3) == 0);

      // one full drain partway through
      if (!drained && sent >= RANDOM_REQUESTS / 2) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
      end

      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        // game done
        send_request(bus_req(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))),
                     1'b0, '0);
      end else if (kind < 16) begin
        // noise
        send_request(bus_req(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))),
                     1'b0, '0);
      end else if (kind < 50) begin
        // read transaction, sometimes cut short or interrupted
        send_request(bus_req(1'b0, 1'b1, 8'($urandom_range(0, 255))), 1'b0, '0);
        n = 0;
        while (sh_phase != i2cm_pkg::PH_ADDR && n < 80) begin
          if ($urandom_range(0, 49) == 0) break;
          if ($urandom_range(0, 39) == 0)
            send_request(bus_req(1'b1, 1'($urandom_range(0, 1)),
                                 8'($urandom_range(0, 255))), 1'b0, '0);
          send_request(bus_req(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))),
                       1'b0, '0);
          n++;
        end
      end else begin
        // write transaction
        text.delete();
        case ($urandom_range(0, 3))
          0: w = i2cm_pkg::WORD_SIMON;
          1: w = i2cm_pkg::WORD_ETCH;
          2: w = i2cm_pkg::WORD_RUBIK;
          default: w = i2cm_pkg::WORD_CARDS;
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            for (int i = 0; i < 5; i++) text.push_back(word_char(w, i));
          end
          4, 5: begin
            for (int i = 0; i < 3; i++)
              text.push_back(word_char({i2cm_pkg::WORD_DIS, 16'h0}, i));
            n = $urandom_range(0, 3);
            repeat (n) text.push_back(8'($urandom_range(1, 255)));
          end
          6: begin
            // near miss of a game word
            for (int i = 0; i < 5; i++) text.push_back(word_char(w, i));
            case ($urandom_range(0, 2))
              0: text[$urandom_range(0, 4)] = 8'($urandom_range(1, 255));
              1: void'(text.pop_back());
              default: text.push_back(8'($urandom_range(1, 255)));
            endcase
          end
          7: begin
            // near miss of the display prefix
            text.push_back("D");
            text.push_back("i");
            text.push_back(8'($urandom_range(1, 255)));
            n = $urandom_range(0, 3);
            repeat (n) text.push_back(8'($urandom_range(1, 255)));
          end
          8: begin
            // long commands run past the buffer
            n = ($urandom_range(0, 2) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 10);
            repeat (n) text.push_back(8'($urandom_range(1, 255)));
          end
          default: begin
            n = $urandom_range(0, 2);
            repeat (n) text.push_back(8'($urandom_range(1, 255)));
          end
        endcase
        send_request(bus_req(1'b0, 1'b0, 8'($urandom_range(0, 255))), 1'b0, '0);
        foreach (text[i]) begin
          if ($urandom_range(0, 39) == 0)
            send_request(bus_req(1'b1, 1'($urandom_range(0, 1)),
                                 8'($urandom_range(0, 255))), 1'b0, '0);
          send_request(bus_req(1'b0, 1'($urandom_range(0, 1)), text[i]), 1'b0, '0);
        end
        if ($urandom_range(0, 9) != 0)
          send_request(bus_req(1'b0, 1'($urandom_range(0, 1)), 8'h00), 1'b0, '0);
      end
    end

    // drain and let any stray result show up
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
